FILE: rtl/core/bounding_sphere_approximator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounding sphere approximator
// Clocked property wrappers, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef BOUNDING_SPHERE_APPROXIMATOR_CORE_ASSERT_SVH
`define BOUNDING_SPHERE_APPROXIMATOR_CORE_ASSERT_SVH

// Check on every edge, reset included.
`define BSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Check only while reset is released.
`define BSA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes for the bounding sphere approximator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // center_method register codes
    localparam logic [2:0] METH_BOX    = 3'd0;
    localparam logic [2:0] METH_MEAN   = 3'd1;
    localparam logic [2:0] METH_PAIR   = 3'd2;
    localparam logic [2:0] METH_BEST   = 3'd3;
    localparam logic [2:0] METH_SPHERE = 3'd4;

    // center candidate, also the method_used code
    typedef enum logic [1:0] {
        CAND_BOX  = 2'd0,
        CAND_MEAN = 2'd1,
        CAND_PAIR = 2'd2
    } t_cand;

    typedef struct packed {
        logic       load;       // store the accepted item
        logic       clr_set;    // drop the collected set
        logic       rd_en;      // read one stored point
        logic       cand_box;   // candidate <= box center
        logic       div_start;  // start mean division on axis
        logic [1:0] axis;
        logic       pi_latch;   // outer pair point <= read data
        logic       pi_first;   // also seed the pair candidate
        logic       d2_start;
        logic       d2_pair;    // distance from outer point, else from candidate
        logic       upd_pair;
        logic       rad_clr;
        logic       upd_rad;
        logic       sq_start;
        logic       best_clr;
        logic       best_upd;
        t_cand      cur;
        logic       add_item;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic d2_done;
        logic sq_done;
    } t_stat;

endpackage

FILE: rtl/core/bsa_dist2.sv
// ----------------------------------------------------------------------------
// bsa_dist2
// Squared 3D distance, one half-width partial product per cycle.
// ----------------------------------------------------------------------------
module bsa_dist2 #(
    parameter int CW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [CW-1:0]  i_a [3],
    input  logic signed [CW-1:0]  i_b [3],
    output logic                  o_done,
    output logic [2*CW+3:0]       o_dist
);
    localparam int DW = CW + 1;
    localparam int H  = (DW + 1) / 2;
    localparam int QW = 2 * DW + 2;

    logic [DW-1:0]    r_mag [3];
    logic             r_busy;
    logic [1:0]       r_axis;
    logic [1:0]       r_part;
    logic             r_pvld;
    logic             r_plast;
    logic [1:0]       r_psel;
    logic [2*H-1:0]   r_pp;
    logic [QW-1:0]    r_acc;
    logic             r_done;

    logic [2*H-1:0]   w_me;
    logic [H-1:0]     w_lo;
    logic [H-1:0]     w_hi;
    logic [H-1:0]     w_x;
    logic [H-1:0]     w_y;
    logic [QW-1:0]    w_sh;
    logic signed [DW-1:0] w_d [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k] = DW'(i_a[k]) - DW'(i_b[k]);
        end
        w_me = (2*H)'(r_mag[r_axis]);
        w_lo = w_me[H-1:0];
        w_hi = w_me[2*H-1:H];
        case (r_part)
            2'd0:    begin w_x = w_lo; w_y = w_lo; end
            2'd1:    begin w_x = w_lo; w_y = w_hi; end
            default: begin w_x = w_hi; w_y = w_hi; end
        endcase
        case (r_psel)
            2'd0:    w_sh = QW'(r_pp);
            2'd1:    w_sh = QW'(r_pp) << (H + 1);
            default: w_sh = QW'(r_pp) << (2 * H);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pvld  <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
            r_axis  <= '0;
            r_part  <= '0;
        end else begin
            r_done <= r_pvld && r_plast;
            r_pvld <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_axis <= '0;
                r_part <= '0;
                r_plast <= 1'b0;
            end else if (r_busy) begin
                r_plast <= (r_axis == 2'd2) && (r_part == 2'd2);
                if (r_part == 2'd2) begin
                    r_part <= '0;
                    if (r_axis == 2'd2) begin
                        r_busy <= 1'b0;
                    end
                    r_axis <= r_axis + 2'd1;
                end else begin
                    r_part <= r_part + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= w_d[k][DW-1] ? DW'(-w_d[k]) : DW'(w_d[k]);
            end
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + w_sh;
        end
        r_pp   <= w_x * w_y;
        r_psel <= r_part;
    end

    assign o_done = r_done;
    assign o_dist = r_acc;

endmodule

FILE: rtl/core/bsa_div.sv
// ----------------------------------------------------------------------------
// bsa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsa_div #(
    parameter int NW = 32,
    parameter int DV = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DV-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [DV-1:0]  r_rem;
    logic [DV-1:0]  r_dv;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DV:0]    w_t;
    logic           w_ge;

    assign w_t  = {r_rem, r_q[NW-1]};
    assign w_ge = w_t >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_dv  <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DV'(w_t - {1'b0, r_dv}) : w_t[DV-1:0];
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/bsa_isqrt.sv
// ----------------------------------------------------------------------------
// bsa_isqrt
// Floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module bsa_isqrt #(
    parameter int QW = 68
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QW-1:0]     i_value,
    output logic              o_done,
    output logic [QW/2-1:0]   o_root
);
    localparam int RQ  = QW / 2;
    localparam int XW  = RQ + 3;
    localparam int CNW = $clog2(RQ + 1);

    logic [QW-1:0]  r_v;
    logic [XW-1:0]  r_rem;
    logic [RQ-1:0]  r_root;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [XW-1:0]  w_t;
    logic [XW-1:0]  w_trial;
    logic           w_ge;

    assign w_t     = {r_rem[XW-3:0], r_v[QW-1:QW-2]};
    assign w_trial = XW'({r_root, 2'b01});
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(RQ);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= r_v << 2;
            r_rem  <= w_ge ? (w_t - w_trial) : w_t;
            r_root <= {r_root[RQ-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/core/bsa_dp.sv
// ----------------------------------------------------------------------------
// bsa_dp
// Point store, set statistics, center candidates and result register.
// ----------------------------------------------------------------------------
module bsa_dp #(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bsa_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_rd_addr,
    input  logic [31:0]                          i_px,
    input  logic [31:0]                          i_py,
    input  logic [31:0]                          i_pz,
    input  logic [30:0]                          i_item,
    output bsa_pkg::t_stat                       o_stat,
    output logic [$clog2(MAX_POINTS+1)-1:0]      o_count,
    output logic [127:0]                         o_tdata,
    output logic [2:0]                           o_tuser
);
    localparam int CW = COORD_WIDTH;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = CW + NW;
    localparam int DW = CW + 1;
    localparam int QW = 2 * DW + 2;
    localparam int RW = QW / 2;

    logic [CW-1:0] mem_x [MAX_POINTS];
    logic [CW-1:0] mem_y [MAX_POINTS];
    logic [CW-1:0] mem_z [MAX_POINTS];

    logic [NW-1:0]         r_count;
    logic signed [CW-1:0]  r_min [3];
    logic signed [CW-1:0]  r_max [3];
    logic signed [SW-1:0]  r_sum [3];
    logic [30:0]           r_item;
    logic                  r_ovf;

    logic signed [CW-1:0]  r_rd   [3];
    logic signed [CW-1:0]  r_cand [3];
    logic signed [CW-1:0]  r_pi   [3];
    logic signed [CW-1:0]  r_best [3];
    logic [QW-1:0]         r_pbest;
    logic [QW-1:0]         r_maxd;
    logic [RW-1:0]         r_brad;
    bsa_pkg::t_cand        r_bm;
    logic                  r_bvld;
    logic                  r_div_neg;
    logic [127:0]          r_tdata;
    logic [2:0]            r_tuser;

    logic [63:0]           w_zx [3];
    logic signed [CW-1:0]  w_pt [3];
    logic                  w_full;
    logic signed [DW-1:0]  w_bs [3];
    logic signed [DW-1:0]  w_ps [3];
    logic signed [CW-1:0]  w_a  [3];
    logic signed [SW-1:0]  w_sax;
    logic [SW-1:0]         w_dvd;
    logic [SW-1:0]         w_quot;
    logic signed [SW-1:0]  w_qs;
    logic                  w_div_done;
    logic                  w_d2_done;
    logic [QW-1:0]         w_d2;
    logic                  w_sq_done;
    logic [RW-1:0]         w_root;
    logic signed [63:0]    w_c64 [3];
    logic [63:0]           w_rad64;
    logic [31:0]           w_rad;

    assign w_full = (r_count == NW'(MAX_POINTS));

    always_comb begin
        w_zx[0] = 64'(i_px);
        w_zx[1] = 64'(i_py);
        w_zx[2] = 64'(i_pz);
        for (int k = 0; k < 3; k++) begin
            w_pt[k] = signed'(w_zx[k][CW-1:0]);
            w_bs[k] = DW'(r_min[k]) + DW'(r_max[k]);
            w_ps[k] = DW'(r_pi[k]) + DW'(r_rd[k]);
            w_a[k]  = i_cmd.d2_pair ? r_pi[k] : r_cand[k];
            w_c64[k] = 64'(r_best[k]);
        end
        w_sax   = r_sum[i_cmd.axis];
        w_dvd   = w_sax[SW-1] ? SW'(-w_sax) : SW'(w_sax);
        w_qs    = r_div_neg ? -signed'(w_quot) : signed'(w_quot);
        w_rad64 = 64'(r_brad) + (i_cmd.add_item ? 64'(r_item) : 64'd0);
        w_rad   = (w_rad64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w_rad64[31:0];
    end

    // point store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            mem_x[r_count[AW-1:0]] <= w_pt[0];
            mem_y[r_count[AW-1:0]] <= w_pt[1];
            mem_z[r_count[AW-1:0]] <= w_pt[2];
        end
        if (i_cmd.rd_en) begin
            r_rd[0] <= signed'(mem_x[i_rd_addr]);
            r_rd[1] <= signed'(mem_y[i_rd_addr]);
            r_rd[2] <= signed'(mem_z[i_rd_addr]);
        end
    end

    // set statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_set) begin
            r_count <= '0;
            r_item  <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= {1'b0, {(CW-1){1'b1}}};
                r_max[k] <= {1'b1, {(CW-1){1'b0}}};
                r_sum[k] <= '0;
            end
        end else if (i_cmd.load) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + NW'(1);
                if (i_item > r_item) begin
                    r_item <= i_item;
                end
                for (int k = 0; k < 3; k++) begin
                    if (w_pt[k] < r_min[k]) r_min[k] <= w_pt[k];
                    if (w_pt[k] > r_max[k]) r_max[k] <= w_pt[k];
                    r_sum[k] <= r_sum[k] + SW'(w_pt[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld    <= 1'b0;
            r_div_neg <= 1'b0;
        end else begin
            if (i_cmd.div_start) r_div_neg <= w_sax[SW-1];
            if (i_cmd.best_clr) begin
                r_bvld <= 1'b0;
            end else if (i_cmd.best_upd) begin
                r_bvld <= 1'b1;
            end
        end
    end

    // candidates, running maxima and the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_box) begin
            for (int k = 0; k < 3; k++) r_cand[k] <= w_bs[k][CW:1];
        end
        if (w_div_done) begin
            r_cand[i_cmd.axis] <= w_qs[CW-1:0];
        end
        if (i_cmd.pi_latch) begin
            for (int k = 0; k < 3; k++) r_pi[k] <= r_rd[k];
            if (i_cmd.pi_first) begin
                for (int k = 0; k < 3; k++) r_cand[k] <= r_rd[k];
                r_pbest <= '0;
            end
        end
        if (i_cmd.upd_pair && w_d2_done && (w_d2 > r_pbest)) begin
            r_pbest <= w_d2;
            for (int k = 0; k < 3; k++) r_cand[k] <= w_ps[k][CW:1];
        end
        if (i_cmd.rad_clr) begin
            r_maxd <= '0;
        end else if (i_cmd.upd_rad && w_d2_done && (w_d2 > r_maxd)) begin
            r_maxd <= w_d2;
        end
        if (i_cmd.best_upd && (!r_bvld || (w_root <= r_brad))) begin
            for (int k = 0; k < 3; k++) r_best[k] <= r_cand[k];
            r_brad <= w_root;
            r_bm   <= i_cmd.cur;
        end
        if (i_cmd.out_load) begin
            r_tdata <= {w_rad, w_c64[2][31:0], w_c64[1][31:0], w_c64[0][31:0]};
            r_tuser <= {r_ovf, r_bm};
        end
    end

    bsa_div #(.NW(SW), .DV(NW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    bsa_dist2 #(.CW(CW)) u_dist2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.d2_start),
        .i_a     (w_a),
        .i_b     (r_rd),
        .o_done  (w_d2_done),
        .o_dist  (w_d2)
    );

    bsa_isqrt #(.QW(QW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_value (r_maxd),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign o_stat.div_done = w_div_done;
    assign o_stat.d2_done  = w_d2_done;
    assign o_stat.sq_done  = w_sq_done;
    assign o_count = r_count;
    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;

endmodule

FILE: rtl/core/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer: load, candidate evaluation, radius passes and result hand-off.
// ----------------------------------------------------------------------------
module bsa_ctrl #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tlast,
    output logic                               o_s_tready,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_wdata,
    input  logic [$clog2(MAX_POINTS+1)-1:0]    i_count,
    input  bsa_pkg::t_stat                     i_stat,
    output bsa_pkg::t_cmd                      o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]      o_rd_addr
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_LOAD, S_START, S_NEXT, S_DIV_GO, S_DIV_WAIT,
        S_PI_RD, S_PI_LAT, S_PJ_RD, S_PJ_GO, S_PJ_WAIT,
        S_RAD_INIT, S_R_RD, S_R_GO, S_R_WAIT, S_SQ_GO, S_SQ_WAIT, S_OUT
    } t_state;

    t_state          r_state;
    logic [2:0]      r_method;
    logic [2:0]      r_todo;      // box, mean, pair still to evaluate
    logic            r_add;
    bsa_pkg::t_cand  r_cur;
    logic [1:0]      r_axis;
    logic [NW-1:0]   r_i;
    logic [NW-1:0]   r_j;
    logic [NW-1:0]   r_k;
    logic            r_out_valid;

    logic            w_fire;
    logic            w_out_free;

    assign w_fire     = (r_state == S_LOAD) && i_s_tvalid;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_method    <= bsa_pkg::METH_BEST;
            r_todo      <= '0;
            r_add       <= 1'b0;
            r_cur       <= bsa_pkg::CAND_BOX;
            r_axis      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_method <= i_cfg_wdata;
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_fire && i_s_tlast) r_state <= S_START;
                end
                S_START: begin
                    r_add <= (r_method == bsa_pkg::METH_SPHERE);
                    unique case (r_method)
                        bsa_pkg::METH_BOX:    r_todo <= 3'b001;
                        bsa_pkg::METH_MEAN:   r_todo <= 3'b010;
                        bsa_pkg::METH_PAIR:   r_todo <= 3'b100;
                        bsa_pkg::METH_SPHERE: r_todo <= 3'b001;
                        default:              r_todo <= 3'b111;
                    endcase
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_todo[0]) begin
                        r_todo[0] <= 1'b0;
                        r_cur     <= bsa_pkg::CAND_BOX;
                        r_state   <= S_RAD_INIT;
                    end else if (r_todo[1]) begin
                        r_todo[1] <= 1'b0;
                        r_cur     <= bsa_pkg::CAND_MEAN;
                        r_axis    <= '0;
                        r_state   <= S_DIV_GO;
                    end else if (r_todo[2]) begin
                        r_todo[2] <= 1'b0;
                        r_cur     <= bsa_pkg::CAND_PAIR;
                        r_i       <= '0;
                        r_state   <= S_PI_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV_GO:   r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_stat.div_done) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_RAD_INIT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_PI_RD:  r_state <= S_PI_LAT;
                S_PI_LAT: begin
                    r_j <= r_i + NW'(1);
                    r_state <= ((r_i + NW'(1)) < i_count) ? S_PJ_RD : S_RAD_INIT;
                end
                S_PJ_RD:   r_state <= S_PJ_GO;
                S_PJ_GO:   r_state <= S_PJ_WAIT;
                S_PJ_WAIT: begin
                    if (i_stat.d2_done) begin
                        if ((r_j + NW'(1)) < i_count) begin
                            r_j     <= r_j + NW'(1);
                            r_state <= S_PJ_RD;
                        end else if ((r_i + NW'(2)) < i_count) begin
                            r_i     <= r_i + NW'(1);
                            r_state <= S_PI_RD;
                        end else begin
                            r_state <= S_RAD_INIT;
                        end
                    end
                end
                S_RAD_INIT: begin
                    r_k     <= '0;
                    r_state <= S_R_RD;
                end
                S_R_RD:   r_state <= S_R_GO;
                S_R_GO:   r_state <= S_R_WAIT;
                S_R_WAIT: begin
                    if (i_stat.d2_done) begin
                        if ((r_k + NW'(1)) < i_count) begin
                            r_k     <= r_k + NW'(1);
                            r_state <= S_R_RD;
                        end else begin
                            r_state <= S_SQ_GO;
                        end
                    end
                end
                S_SQ_GO:   r_state <= S_SQ_WAIT;
                S_SQ_WAIT: begin
                    if (i_stat.sq_done) r_state <= S_NEXT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_fire;
        o_cmd.axis      = r_axis;
        o_cmd.cur       = r_cur;
        o_cmd.add_item  = r_add;
        o_cmd.cand_box  = (r_state == S_NEXT) && r_todo[0];
        o_cmd.div_start = (r_state == S_DIV_GO);
        o_cmd.rd_en     = (r_state == S_PI_RD) || (r_state == S_PJ_RD) ||
                          (r_state == S_R_RD);
        o_cmd.pi_latch  = (r_state == S_PI_LAT);
        o_cmd.pi_first  = (r_state == S_PI_LAT) && (r_i == '0);
        o_cmd.d2_start  = (r_state == S_PJ_GO) || (r_state == S_R_GO);
        o_cmd.d2_pair   = (r_state == S_PJ_GO);
        o_cmd.upd_pair  = (r_state == S_PJ_WAIT);
        o_cmd.rad_clr   = (r_state == S_RAD_INIT);
        o_cmd.upd_rad   = (r_state == S_R_WAIT);
        o_cmd.sq_start  = (r_state == S_SQ_GO);
        o_cmd.best_clr  = (r_state == S_START);
        o_cmd.best_upd  = (r_state == S_SQ_WAIT) && i_stat.sq_done;
        o_cmd.out_load  = (r_state == S_OUT) && w_out_free;
        o_cmd.clr_set   = (r_state == S_OUT) && w_out_free;
        case (r_state)
            S_PI_RD: o_rd_addr = r_i[AW-1:0];
            S_PJ_RD: o_rd_addr = r_j[AW-1:0];
            default: o_rd_addr = r_k[AW-1:0];
        endcase
    end

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = r_out_valid;

endmodule

FILE: rtl/core/bounding_sphere_approximator_core.sv
// ----------------------------------------------------------------------------
// bounding_sphere_approximator_core
// Collects a 3D point set and reports one approximate enclosing sphere.
// ----------------------------------------------------------------------------
// Input stream: one point per item (x, y, z, item radius), tlast closes the
// set. Points are taken one per cycle while the block is collecting. After the
// closing item the block drops tready and computes; each candidate center
// costs one radius pass over the stored points plus a square root. The mean
// adds three serial divisions, and the farthest-pair search adds a pass over
// every pair of stored points; the radius and pair passes are bound by the
// single shared squared-distance unit (one half-width product per cycle) and
// the single read port of the point store. Best-of-three runs all three
// candidates. The result sits in an output register; tready returns as soon
// as it is loaded, so the next set loads while the receiver stalls. A
// finished result waits inside the block until the register frees up.
// Reset (synchronous, active low) empties the set, selects best-of-three and
// clears the output valid. Points past MAX_POINTS are dropped and flagged.
// ----------------------------------------------------------------------------
module bounding_sphere_approximator_core #(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_wdata,  // center_method
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,    // point_x, point_y, point_z, item_radius, pad
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,    // center_x, center_y, center_z, sphere_radius
    output logic [2:0]   o_m_tuser     // method_used, overflow
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    bsa_pkg::t_cmd   w_cmd;
    bsa_pkg::t_stat  w_stat;
    logic [AW-1:0]   w_rd_addr;
    logic [NW-1:0]   w_count;

    // sequencer: owns both handshakes and the method register
    bsa_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tlast   (i_s_tlast),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_count     (w_count),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    // store, arithmetic units and the result register
    bsa_dp #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rd_addr (w_rd_addr),
        .i_px      (i_s_tdata[31:0]),
        .i_py      (i_s_tdata[63:32]),
        .i_pz      (i_s_tdata[95:64]),
        .i_item    (i_s_tdata[126:96]),
        .o_stat    (w_stat),
        .o_count   (w_count),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser)
    );

endmodule

FILE: rtl/core/bsa_checker.sv
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks for the bounding sphere approximator.
// ----------------------------------------------------------------------------
`include "bounding_sphere_approximator_core_assert.svh"

module bsa_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         i_s_tlast,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [127:0] o_m_tdata,
    input logic [2:0]   o_m_tuser
);
    // reset empties the output register
    `BSA_ASSERT(a_rst_clears, (!i_rst_n |=> !o_m_tvalid), "output valid after reset")

    // closing item stops intake for the compute phase
    `BSA_ASSERT_RST(a_last_stops, ((i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready), "intake open after last item")

    // a result appears only after a compute phase
    `BSA_ASSERT_RST(a_rise_after_compute, ($rose(o_m_tvalid) |-> $past(!o_s_tready)), "result without compute")

    // stalled result holds
    `BSA_ASSERT_RST(a_stall_hold, ((o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))), "stalled result changed")

endmodule

bind bounding_sphere_approximator_core bsa_checker u_bsa_checker (.*);
